// ===== hdl/gr57_pkg.sv =====
// Shared types, constants, font table and character lookup for the 5x7 glyph rasterizer.
package gr57_pkg;

  localparam int GlyphRows  = 7;
  localparam int GlyphCols  = 5;
  localparam int GlyphCount = 30;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = FifoPtrW + 1;

  localparam logic [2:0] LastRow = 3'(GlyphRows - 1);

  typedef logic [4:0] glyph_idx_t;
  typedef logic [2:0] row_idx_t;
  typedef logic [GlyphCols-1:0] row_bits_t;

  // One character job as it waits between the front end and the scanner.
  typedef struct packed {
    logic [7:0] ink_color;
    glyph_idx_t glyph;
    logic [7:0] origin_y;
    logic [7:0] origin_x;
  } job_t;

  typedef struct packed {
    logic       hit;
    glyph_idx_t idx;
  } glyph_sel_t;

  // Bit 4 of each row is the leftmost column; row 0 is the top row.
  localparam row_bits_t FONT_ROM [GlyphCount][GlyphRows] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}, // A
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}, // B
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}, // C
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}, // E
    '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E}, // G
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}, // H
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F}, // I
    '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}, // K
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}, // L
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}, // M
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}, // N
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // O
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}, // P
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}, // R
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}, // S
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}, // T
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // U
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}, // V
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11}, // W
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11}, // X
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}, // 0
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}, // 1
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}, // 2
    '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}, // 3
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}, // 4
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}, // 5
    '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}, // 6
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}, // 7
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}, // 8
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}  // 9
  };

  // ASCII codes of the characters that have a glyph.
  localparam logic [7:0] ChrZero = 8'h30;
  localparam logic [7:0] ChrNine = 8'h39;
  localparam logic [7:0] ChrA = 8'h41;
  localparam logic [7:0] ChrB = 8'h42;
  localparam logic [7:0] ChrC = 8'h43;
  localparam logic [7:0] ChrE = 8'h45;
  localparam logic [7:0] ChrG = 8'h47;
  localparam logic [7:0] ChrH = 8'h48;
  localparam logic [7:0] ChrI = 8'h49;
  localparam logic [7:0] ChrK = 8'h4B;
  localparam logic [7:0] ChrL = 8'h4C;
  localparam logic [7:0] ChrM = 8'h4D;
  localparam logic [7:0] ChrN = 8'h4E;
  localparam logic [7:0] ChrO = 8'h4F;
  localparam logic [7:0] ChrP = 8'h50;
  localparam logic [7:0] ChrR = 8'h52;
  localparam logic [7:0] ChrS = 8'h53;
  localparam logic [7:0] ChrT = 8'h54;
  localparam logic [7:0] ChrU = 8'h55;
  localparam logic [7:0] ChrV = 8'h56;
  localparam logic [7:0] ChrW = 8'h57;
  localparam logic [7:0] ChrX = 8'h58;

  localparam glyph_idx_t DigitBase = 5'd20;

  // Map a character code to its font table row; hit is low for codes without a glyph.
  function automatic glyph_sel_t glyph_lookup(input logic [7:0] code);
    glyph_sel_t sel;
    sel.hit = 1'b1;
    sel.idx = '0;
    if (code inside {[ChrZero:ChrNine]}) begin
      sel.idx = DigitBase + 5'(code - ChrZero);
    end else begin
      case (code)
        ChrA: sel.idx = 5'd0;
        ChrB: sel.idx = 5'd1;
        ChrC: sel.idx = 5'd2;
        ChrE: sel.idx = 5'd3;
        ChrG: sel.idx = 5'd4;
        ChrH: sel.idx = 5'd5;
        ChrI: sel.idx = 5'd6;
        ChrK: sel.idx = 5'd7;
        ChrL: sel.idx = 5'd8;
        ChrM: sel.idx = 5'd9;
        ChrN: sel.idx = 5'd10;
        ChrO: sel.idx = 5'd11;
        ChrP: sel.idx = 5'd12;
        ChrR: sel.idx = 5'd13;
        ChrS: sel.idx = 5'd14;
        ChrT: sel.idx = 5'd15;
        ChrU: sel.idx = 5'd16;
        ChrV: sel.idx = 5'd17;
        ChrW: sel.idx = 5'd18;
        ChrX: sel.idx = 5'd19;
        default: sel.hit = 1'b0;
      endcase
    end
    return sel;
  endfunction

  // One row of a glyph; out-of-range indexes read as a blank row.
  function automatic row_bits_t font_row(input glyph_idx_t glyph, input row_idx_t row);
    row_bits_t bits;
    bits = '0;
    if ((32'(glyph) < GlyphCount) && (32'(row) < GlyphRows)) begin
      bits = FONT_ROM[glyph][row];
    end
    return bits;
  endfunction

endpackage

// ===== hdl/glyph_rasterizer_5x7_top.sv =====
// Top level of the 5x7 glyph rasterizer: front end, job queue and glyph scanner.
//
// Each input word names a character, the origin of its 5x7 cell and an ink
// color; the block answers with one pixel word per lit font bit, in row order
// top to bottom and left to right within a row, and raises tlast on the final
// pixel of the character. Coordinates wrap modulo 256. Characters without a
// glyph (anything but A B C E G H I K L M N O P R S T U V W X and 0 to 9) are
// accepted and produce no pixels. The scanner emits exactly one pixel per
// cycle while the output is taken; each glyph has from 10 up to 20 lit bits,
// and consecutive queued characters follow with no gap; the pixel rate is set
// by the single-pixel output register of the scanner. A four-entry job queue
// separates the front end from the scanner, so new characters keep being
// accepted while a glyph is still being drawn or while a finished pixel waits
// for the consumer. An accepted character is written into the queue, loaded
// into the scanner's job and row registers, then registered as its first pixel
// word. No configuration registers; only the queue and scanner hold state.
module glyph_rasterizer_5x7_top
  import gr57_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // origin_x [7:0], origin_y [15:8], char_code [23:16], ink_color [31:24]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_x [7:0], pixel_y [15:8], pixel_color [23:16]
  output logic [23:0] m_axis_tdata_o,
  // last_pixel
  output logic        m_axis_tlast_o
);

  logic push, queue_ready, job_valid, pop;
  job_t push_job, head_job;

  // The front end classifies each word and drops characters with no glyph.
  gr57_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_o          (push),
    .job_o           (push_job),
    .queue_ready_i   (queue_ready)
  );

  // The queue lets the front end keep accepting while the scanner is busy.
  gr57_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .ready_o     (queue_ready),
    .valid_o     (job_valid),
    .pop_data_o  (head_job),
    .pop_i       (pop)
  );

  // The scanner pops the next job when idle or on the cycle it registers the last pixel.
  gr57_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (head_job),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== hdl/gr57_front.sv =====
// Front end: accepts character words, looks up the glyph and queues drawable characters.
module gr57_front
  import gr57_pkg::*;
(
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        queue_ready_i
);

  glyph_sel_t sel;

  assign sel = glyph_lookup(s_axis_tdata_i[23:16]);

  // A word is taken whenever the queue has room; characters without a glyph
  // are consumed here and never reach the scanner.
  assign s_axis_tready_o = queue_ready_i;
  assign push_o          = s_axis_tvalid_i && queue_ready_i && sel.hit;

  assign job_o.origin_x  = s_axis_tdata_i[7:0];
  assign job_o.origin_y  = s_axis_tdata_i[15:8];
  assign job_o.glyph     = sel.idx;
  assign job_o.ink_color = s_axis_tdata_i[31:24];

endmodule

// ===== hdl/gr57_fifo.sv =====
// Small job queue between the front end and the glyph scanner.
module gr57_fifo
  import gr57_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic ready_o,
  output logic valid_o,
  output job_t pop_data_o,
  input  logic pop_i
);

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign ready_o    = count_q != FifoCntW'(FifoDepth);
  assign valid_o    = count_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("queue fill count beyond its depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FifoCntW'(FifoDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== hdl/gr57_back.sv =====
// Glyph scanner: walks the lit bits of a queued glyph and emits one pixel word per cycle while the output is taken.
module gr57_back
  import gr57_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic       busy_q, busy_d;
  row_idx_t   row_q, row_d;
  row_bits_t  mask_q, mask_d;
  job_t       job_q, job_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] px_q, px_d, py_q, py_d, pc_q, pc_d;
  logic       last_q, last_d;

  row_bits_t  sel;
  row_bits_t  mask_rest;
  logic [2:0] col;
  logic       row_done, last_pix, adv, take;

  // Leftmost remaining lit column of the current row.
  always_comb begin
    case (mask_q) inside
      5'b1????: begin col = 3'd0; sel = 5'b10000; end
      5'b01???: begin col = 3'd1; sel = 5'b01000; end
      5'b001??: begin col = 3'd2; sel = 5'b00100; end
      5'b0001?: begin col = 3'd3; sel = 5'b00010; end
      5'b00001: begin col = 3'd4; sel = 5'b00001; end
      default:  begin col = 3'd0; sel = 5'b00000; end
    endcase
  end

  assign mask_rest = mask_q & ~sel;
  assign row_done  = mask_rest == '0;
  assign last_pix  = row_done && (row_q == LastRow);
  assign adv       = busy_q && (!out_valid_q || m_axis_tready_i);
  assign take      = job_valid_i && (!busy_q || (adv && last_pix));
  assign pop_o     = take;

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    mask_d = mask_q;
    job_d  = job_q;
    if (take) begin
      busy_d = 1'b1;
      job_d  = job_i;
      row_d  = '0;
      mask_d = font_row(job_i.glyph, '0);
    end else if (adv) begin
      if (last_pix) begin
        busy_d = 1'b0;
      end else if (row_done) begin
        row_d  = row_q + 1'b1;
        mask_d = font_row(job_q.glyph, row_q + 1'b1);
      end else begin
        mask_d = mask_rest;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    pc_d        = pc_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = 1'b1;
      px_d        = job_q.origin_x + 8'(col);
      py_d        = job_q.origin_y + 8'(row_q);
      pc_d        = job_q.ink_color;
      last_d      = last_pix;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    mask_q <= mask_d;
    job_q  <= job_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pc_q   <= pc_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {pc_q, py_q, px_q};
  assign m_axis_tlast_o  = last_q;

`ifndef SYNTHESIS
  a_busy_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> mask_q != '0)
    else $error("scanner busy on an empty row");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> row_q <= LastRow)
    else $error("scanner row beyond the glyph cell");
`endif

endmodule

// ===== tb/sv/tb_glyph_rasterizer_5x7_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 5x7 glyph rasterizer: characters in, predicted pixel words out.

package tb_glyph_pixel_pkg;
  import gr57_pkg::*;

  // One pixel write as the block reports it.
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] color;
    logic       last;
  } pixel_t;

  // Character codes that own a glyph, in the order of the bitmap table below.
  localparam logic [7:0] GlyphCodes [GlyphCount] = '{
    "A", "B", "C", "E", "G", "H", "I", "K", "L", "M",
    "N", "O", "P", "R", "S", "T", "U", "V", "W", "X",
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9"
  };

  // Glyph bitmaps, top row first; bit 4 is the leftmost column.
  localparam logic [4:0] GlyphBits [GlyphCount][GlyphRows] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}
  };

  // Slot of a code in the bitmap table, or -1 when it draws nothing.
  function automatic int glyph_slot(input logic [7:0] code);
    int slot;
    slot = -1;
    for (int i = 0; i < GlyphCount; i++) begin
      if (GlyphCodes[i] == code) slot = i;
    end
    return slot;
  endfunction

  class pixel_scoreboard;
    pixel_t      expected_pixels[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_chars;
    int unsigned n_blank;

    // Expand one accepted character into its pixel writes, in scan order.
    function void note_char(input logic [7:0] ox, input logic [7:0] oy,
                            input logic [7:0] code, input logic [7:0] ink);
      int     slot;
      bit     have_prev;
      pixel_t prev;
      logic [4:0] bits;
      slot = glyph_slot(code);
      have_prev = 1'b0;
      n_chars++;
      if (slot < 0) begin
        n_blank++;
        return;
      end
      for (int r = 0; r < GlyphRows; r++) begin
        bits = GlyphBits[slot][r];
        for (int c = 0; c < GlyphCols; c++) begin
          if (bits[GlyphCols-1-c]) begin
            if (have_prev) expected_pixels.push_back(prev);
            prev.x     = 8'(ox + c);
            prev.y     = 8'(oy + r);
            prev.color = ink;
            prev.last  = 1'b0;
            have_prev  = 1'b1;
          end
        end
      end
      // Every glyph has lit bits, so the held pixel is the final one.
      prev.last = 1'b1;
      expected_pixels.push_back(prev);
    endfunction

    function void check_pixel(input pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d color=%0h last=%0b",
                 $time, got.x, got.y, got.color, got.last);
        return;
      end
      want = expected_pixels.pop_front();
      n_checked++;
      if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
          got.last !== want.last) begin
        n_errors++;
        $display("%0t: pixel mismatch, expected x=%0d y=%0d color=%0h last=%0b, got x=%0d y=%0d color=%0h last=%0b",
                 $time, want.x, want.y, want.color, want.last,
                 got.x, got.y, got.color, got.last);
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

endpackage

module tb_glyph_rasterizer_5x7_top;
  import gr57_pkg::*;
  import tb_glyph_pixel_pkg::*;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 5;
  localparam int RandomChars   = 190;
  // Quiet cycles at the end catch any stray word after the last expected pixel.
  localparam int DrainCycles   = 40;
  // Slowest honest run: ~215 characters of at most 20 pixels, each pixel
  // waiting out a heavy receiver stall, plus sender gaps and the hold-off.
  // The bound sits far above that, so it only trips on a hang.
  localparam int CycleLimit    = 800000;
  localparam int HoldOffCycles = 400;
  localparam int HoldOffAfter  = 120;

  // Codes that must draw nothing: neighbors of the digit range, letters that
  // the font leaves out, lower case, and both ends of the code space.
  localparam logic [7:0] ChrNul    = 8'h00;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrSlash  = 8'h2F;
  localparam logic [7:0] ChrColon  = 8'h3A;
  localparam logic [7:0] ChrAt     = 8'h40;
  localparam logic [7:0] ChrD      = 8'h44;
  localparam logic [7:0] ChrJ      = 8'h4A;
  localparam logic [7:0] ChrQ      = 8'h51;
  localparam logic [7:0] ChrY      = 8'h59;
  localparam logic [7:0] ChrZ      = 8'h5A;
  localparam logic [7:0] ChrLowA   = 8'h61;
  localparam logic [7:0] ChrTop    = 8'hFF;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tlast;

  pixel_scoreboard sb;
  int unsigned     cycles     = 0;
  int unsigned     burst_left = 0;
  bit              held_off   = 1'b0;

  glyph_rasterizer_5x7_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #(ClkHalf) clk = 1'b1;
    #(ClkHalf) clk = 1'b0;
  end

  // Watchdog: a run that has not finished by now is hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: run stopped after %0d cycles with %0d pixels outstanding",
               $time, cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output monitor. Values are read right at the edge, before the block's
  // registers update, so each word is seen as it was during the cycle.
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      sb.check_pixel(pixel_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast}));
    end
  end

  // Receiver. It runs in segments of random length, each with its own stall
  // rate, from never stalling to stalling almost every cycle. Once, after
  // enough pixels have passed, it holds tready low for a long stretch while
  // the sender keeps offering characters, so the job queue fills and the
  // block has to push back on its input.
  initial begin : receiver
    int seg_len;
    int stall_pct;
    @(posedge clk);
    forever begin
      seg_len = $urandom_range(20, 150);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
      repeat (seg_len) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        @(posedge clk);
      end
      if (!held_off && sb.n_checked >= HoldOffAfter) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
    end
  end

  // Offer one character word and wait until it is taken. The sender works in
  // bursts: when a burst is used up it drops tvalid for a random gap first.
  // Back-to-back words keep tvalid high with a single assignment per edge.
  task automatic send_char(input logic [7:0] ox, input logic [7:0] oy,
                           input logic [7:0] code, input logic [7:0] ink);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {ink, code, oy, ox};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_char(ox, oy, code, ink);
  endtask

  // Coordinates lean toward the top of the range so that cells often cross
  // the wrap at 255 in x, y or both.
  function automatic logic [7:0] pick_coord();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(248, 255));
    return 8'($urandom);
  endfunction

  initial begin : stimulus
    logic [7:0] code;
    sb = new;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Corners of the coordinate space, cells that wrap on
    // one or both axes, both extremes of the ink color, the densest glyph,
    // sparse ones, and a run of codes that have no glyph at all.
    send_char(8'd0,   8'd0,   ChrA,    8'h00);
    send_char(8'd255, 8'd255, ChrW,    8'hFF);
    send_char(8'd252, 8'd250, ChrB,    8'h5A);
    send_char(8'd0,   8'd128, ChrI,    8'hA5);
    send_char(8'd10,  8'd10,  ChrSpace, 8'h11);
    send_char(8'd20,  8'd20,  ChrLowA, 8'h22);
    send_char(8'd30,  8'd30,  ChrNul,  8'h33);
    send_char(8'd255, 8'd0,   ChrTop,  8'hFF);
    send_char(8'd40,  8'd40,  ChrSlash, 8'h44);
    send_char(8'd50,  8'd50,  ChrColon, 8'h55);
    send_char(8'd60,  8'd60,  ChrAt,   8'h66);
    send_char(8'd70,  8'd70,  ChrD,    8'h77);
    send_char(8'd80,  8'd80,  ChrJ,    8'h88);
    send_char(8'd90,  8'd90,  ChrQ,    8'h99);
    send_char(8'd100, 8'd100, ChrY,    8'hAA);
    send_char(8'd110, 8'd110, ChrZ,    8'hBB);
    send_char(8'd251, 8'd0,   ChrZero, 8'hC3);
    send_char(8'd0,   8'd249, ChrNine, 8'h3C);
    send_char(8'd128, 8'd127, ChrM,    8'h0F);
    send_char(8'd127, 8'd128, ChrX,    8'hF0);
    send_char(8'd255, 8'd251, ChrE,    8'h81);
    send_char(8'd1,   8'd2,   ChrT,    8'h7E);
    send_char(8'd3,   8'd4,   ChrT,    8'h7E);

    // Random part: mostly characters with a glyph, the rest arbitrary codes.
    for (int n = 0; n < RandomChars; n++) begin
      code = ($urandom_range(0, 4) != 0) ? GlyphCodes[$urandom_range(0, GlyphCount-1)]
                                         : 8'($urandom);
      send_char(pick_coord(), pick_coord(), code, 8'($urandom));
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Drew %0d characters (%0d without a glyph) into %0d checked pixel words.",
             sb.n_chars, sb.n_blank, sb.n_checked);
    $display("Coordinates wrapped past 255, receiver hold-off of %0d cycles %s, %0d mismatches.",
             HoldOffCycles, held_off ? "done" : "not reached", sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
